// ----- hdl/pqm_pkg.sv -----
// pqm_pkg: shared types and constants of the per-id quota meter
// no dependencies; used by every module of the block but pqm_queue

package pqm_pkg;

    // opcodes carried in s_tuser
    localparam logic [2:0] OP_CHECK  = 3'd0;
    localparam logic [2:0] OP_RECORD = 3'd1;
    localparam logic [2:0] OP_QKEY   = 3'd2;
    localparam logic [2:0] OP_QGROUP = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // verdict codes
    localparam logic [1:0] VD_ALLOW     = 2'd0;
    localparam logic [1:0] VD_KEY_COST  = 2'd1;
    localparam logic [1:0] VD_KEY_TOKEN = 2'd2;
    localparam logic [1:0] VD_GRP_COST  = 2'd3;

    // splitmix64 finalizer multipliers
    localparam logic [63:0] MIX_A = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_B = 64'h94d049bb133111eb;

    localparam int IN_W  = 360;
    localparam int OUT_W = 104;

    // one accepted request
    typedef struct packed {
        logic [2:0]  opcode;
        logic [63:0] key_ident;
        logic [63:0] group_ident;
        logic [31:0] cost_amount;
        logic [31:0] token_amount;
        logic [47:0] key_cost_limit;
        logic [47:0] key_token_limit;
        logic [47:0] group_cost_limit;
        logic [23:0] period_stamp;
    } req_t;

    // one result, verdict in the lowest bits
    typedef struct packed {
        logic        record_dropped;
        logic [47:0] usage_tokens;
        logic [47:0] usage_cost;
        logic        query_ok;
        logic [1:0]  verdict;
    } res_t;

    // one way of a key bucket
    typedef struct packed {
        logic        valid;
        logic [63:0] ident;
        logic [47:0] cost;
        logic [47:0] tokens;
    } key_way_t;

    // one way of a group bucket
    typedef struct packed {
        logic        valid;
        logic [63:0] ident;
        logic [47:0] cost;
    } grp_way_t;

endpackage

// ----- hdl/pqm_hash.sv -----
// pqm_hash: multi-cycle splitmix64 finalizer and bucket index (hash mod BUCKETS)
// uses pqm_pkg for the mixing constants

module pqm_hash #(
    parameter int BUCKETS = 1024,
    localparam int BIW = $clog2(BUCKETS)
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [63:0]    ident,
    input  logic           ack,
    output logic           done,
    output logic [BIW-1:0] bucket
);

    localparam int DBITS = 4;
    localparam int STEPS = 64 / DBITS;
    localparam int CW    = $clog2(STEPS);
    localparam logic [BIW:0] BMOD = (BIW + 1)'(BUCKETS);

    localparam logic [1:0] H_IDLE = 2'd0;
    localparam logic [1:0] H_MUL  = 2'd1;
    localparam logic [1:0] H_MOD  = 2'd2;
    localparam logic [1:0] H_DONE = 2'd3;

    logic [1:0]     state_reg;
    logic           sel_reg;
    logic [1:0]     part_reg;
    logic [CW-1:0]  cnt_reg;
    logic [63:0]    v_reg;
    logic [63:0]    acc_reg;
    logic [63:0]    h_reg;
    logic [BIW-1:0] rem_reg;

    logic [63:0]    coef;
    logic [31:0]    mul_a;
    logic [31:0]    mul_b;
    logic [63:0]    prod;
    logic [63:0]    sum;
    logic [BIW:0]   r;
    logic [BIW-1:0] rem_next;

    // one 32x32 partial product a cycle, low 64 bits accumulated
    always_comb begin
        coef  = sel_reg ? pqm_pkg::MIX_B : pqm_pkg::MIX_A;
        mul_a = (part_reg == 2'd1) ? v_reg[63:32] : v_reg[31:0];
        mul_b = (part_reg == 2'd2) ? coef[63:32] : coef[31:0];
        prod  = 64'(mul_a) * 64'(mul_b);
        sum   = (part_reg == 2'd0) ? prod : acc_reg + {prod[31:0], 32'd0};
    end

    // remainder, a few bits a cycle, msb first
    always_comb begin
        r = {1'b0, rem_reg};
        for (int i = 0; i < DBITS; i++) begin
            r = {r[BIW-1:0], h_reg[63-i]};
            if (r >= BMOD) begin
                r = r - BMOD;
            end
        end
        rem_next = r[BIW-1:0];
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= H_IDLE;
            sel_reg   <= 1'b0;
            part_reg  <= 2'd0;
            cnt_reg   <= '0;
        end else begin
            unique case (state_reg)
                H_IDLE: begin
                    if (start) begin
                        sel_reg   <= 1'b0;
                        part_reg  <= 2'd0;
                        state_reg <= H_MUL;
                    end
                end
                H_MUL: begin
                    if (part_reg == 2'd2) begin
                        part_reg <= 2'd0;
                        sel_reg  <= 1'b1;
                        if (sel_reg) begin
                            cnt_reg   <= '0;
                            state_reg <= H_MOD;
                        end
                    end else begin
                        part_reg <= part_reg + 2'd1;
                    end
                end
                H_MOD: begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(STEPS - 1)) begin
                        state_reg <= H_DONE;
                    end
                end
                H_DONE: begin
                    if (ack) begin
                        state_reg <= H_IDLE;
                    end
                end
                default: state_reg <= H_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (state_reg == H_IDLE && start) begin
            v_reg <= ident ^ (ident >> 30);
        end
        if (state_reg == H_MUL) begin
            acc_reg <= sum;
            if (part_reg == 2'd2) begin
                if (!sel_reg) begin
                    v_reg <= sum ^ (sum >> 27);
                end else begin
                    h_reg   <= sum ^ (sum >> 31);
                    rem_reg <= '0;
                end
            end
        end
        if (state_reg == H_MOD) begin
            h_reg   <= h_reg << DBITS;
            rem_reg <= rem_next;
        end
    end

    assign done   = (state_reg == H_DONE);
    assign bucket = rem_reg;

endmodule

// ----- hdl/pqm_front.sv -----
// pqm_front: accepts request transactions and hashes key and group ids
// uses pqm_pkg and pqm_hash; feeds the request queue

module pqm_front #(
    parameter int BUCKETS = 1024,
    localparam int BIW = $clog2(BUCKETS)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [pqm_pkg::IN_W-1:0] s_tdata,
    input  logic [2:0]               s_tuser,
    input  logic                     hold,
    input  logic                     q_full,
    output logic                     q_push,
    output pqm_pkg::req_t            q_req,
    output logic [BIW-1:0]           q_kb,
    output logic [BIW-1:0]           q_gb
);

    logic          busy_reg;
    pqm_pkg::req_t req_reg;
    logic          take;
    logic          kdone;
    logic          gdone;

    assign s_tready = !busy_reg && !hold;
    assign take     = s_tvalid && s_tready;
    assign q_push   = busy_reg && kdone && gdone && !q_full;

    // busy from accept until the request is queued
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (take) begin
            busy_reg <= 1'b1;
        end else if (q_push) begin
            busy_reg <= 1'b0;
        end
    end

    // capture the transaction
    always_ff @(posedge aclk) begin
        if (take) begin
            req_reg.opcode           <= s_tuser;
            req_reg.key_ident        <= s_tdata[63:0];
            req_reg.group_ident      <= s_tdata[127:64];
            req_reg.cost_amount      <= s_tdata[159:128];
            req_reg.token_amount     <= s_tdata[191:160];
            req_reg.key_cost_limit   <= s_tdata[239:192];
            req_reg.key_token_limit  <= s_tdata[287:240];
            req_reg.group_cost_limit <= s_tdata[335:288];
            req_reg.period_stamp     <= s_tdata[359:336];
        end
    end

    pqm_hash #(.BUCKETS(BUCKETS)) u_khash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (take),
        .ident   (s_tdata[63:0]),
        .ack     (q_push),
        .done    (kdone),
        .bucket  (q_kb)
    );

    pqm_hash #(.BUCKETS(BUCKETS)) u_ghash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (take),
        .ident   (s_tdata[127:64]),
        .ack     (q_push),
        .done    (gdone),
        .bucket  (q_gb)
    );

    assign q_req = req_reg;

endmodule

// ----- hdl/pqm_queue.sv -----
// pqm_queue: two-entry request queue between front and back
// no package dependencies

module pqm_queue #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic         full,
    output logic         valid,
    output logic [W-1:0] rdata
);

    logic [W-1:0] data_reg [2];
    logic         wptr_reg;
    logic         rptr_reg;
    logic [1:0]   cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign rdata = data_reg[rptr_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) begin
                wptr_reg <= !wptr_reg;
            end
            if (pop) begin
                rptr_reg <= !rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// ----- hdl/pqm_back.sv -----
// pqm_back: executes queued requests against the key and group bucket tables
// uses pqm_pkg; holds both table memories and the result register

module pqm_back #(
    parameter int BUCKETS = 1024,
    parameter int WAYS = 4,
    localparam int BIW = $clog2(BUCKETS)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    input  pqm_pkg::req_t             q_req,
    input  logic [BIW-1:0]            q_kb,
    input  logic [BIW-1:0]            q_gb,
    output logic                      q_pop,
    output logic                      init_busy,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [pqm_pkg::OUT_W-1:0] m_tdata
);

    localparam int WIW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;

    localparam logic [2:0] B_SWEEP = 3'd0;
    localparam logic [2:0] B_IDLE  = 3'd1;
    localparam logic [2:0] B_READ  = 3'd2;
    localparam logic [2:0] B_LOOK  = 3'd3;
    localparam logic [2:0] B_EXEC  = 3'd4;
    localparam logic [2:0] B_RESP  = 3'd5;

    pqm_pkg::key_way_t [WAYS-1:0] kmem [BUCKETS];
    pqm_pkg::grp_way_t [WAYS-1:0] gmem [BUCKETS];

    logic [2:0]     state_reg;
    logic           init_reg;
    logic [BIW-1:0] idx_reg;
    logic [23:0]    period_reg;
    pqm_pkg::req_t  cmd_reg;
    logic [BIW-1:0] kb_reg;
    logic [BIW-1:0] gb_reg;
    pqm_pkg::key_way_t [WAYS-1:0] krow_reg;
    pqm_pkg::grp_way_t [WAYS-1:0] grow_reg;
    logic           khit_reg, kfree_reg, ghit_reg, gfree_reg;
    logic [WIW-1:0] khit_idx_reg, kfree_idx_reg, ghit_idx_reg, gfree_idx_reg;
    pqm_pkg::res_t  res_reg;
    logic           m_valid_reg;
    pqm_pkg::res_t  m_data_reg;

    logic           roll;
    logic           out_free;
    logic           khit, kfree, ghit, gfree;
    logic [WIW-1:0] khit_idx, kfree_idx, ghit_idx, gfree_idx;
    logic           kpos, gpos;
    pqm_pkg::key_way_t kent;
    pqm_pkg::grp_way_t gent;
    logic [47:0]    ksum_c, ksum_t, gsum_c;
    logic [WIW-1:0] kway, gway;
    pqm_pkg::key_way_t [WAYS-1:0] krow_upd;
    pqm_pkg::grp_way_t [WAYS-1:0] grow_upd;
    pqm_pkg::res_t  res_exec;
    logic           k_wr, g_wr;
    logic           kwe, gwe;
    logic [BIW-1:0] kwaddr, gwaddr;
    pqm_pkg::key_way_t [WAYS-1:0] kwdata;
    pqm_pkg::grp_way_t [WAYS-1:0] gwdata;

    function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[48] ? SAT48 : s[47:0];
    endfunction

    assign init_busy = init_reg;
    assign out_free  = !m_valid_reg || m_tready;
    assign q_pop     = (state_reg == B_IDLE) && q_valid;
    assign roll      = (q_req.opcode == pqm_pkg::OP_CLEAR)
                    || (((q_req.opcode == pqm_pkg::OP_CHECK)
                      || (q_req.opcode == pqm_pkg::OP_RECORD))
                      && (q_req.period_stamp != period_reg));

    // way search over the fetched rows
    always_comb begin
        khit = 1'b0; kfree = 1'b0; ghit = 1'b0; gfree = 1'b0;
        khit_idx = '0; kfree_idx = '0; ghit_idx = '0; gfree_idx = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (krow_reg[w].valid && krow_reg[w].ident == cmd_reg.key_ident) begin
                khit = 1'b1;
                khit_idx = WIW'(w);
            end
            if (!krow_reg[w].valid) begin
                kfree = 1'b1;
                kfree_idx = WIW'(w);
            end
            if (grow_reg[w].valid && grow_reg[w].ident == cmd_reg.group_ident) begin
                ghit = 1'b1;
                ghit_idx = WIW'(w);
            end
            if (!grow_reg[w].valid) begin
                gfree = 1'b1;
                gfree_idx = WIW'(w);
            end
        end
    end

    // execute one request on the matched ways
    always_comb begin
        kpos   = (cmd_reg.key_ident != 64'd0) && !cmd_reg.key_ident[63];
        gpos   = (cmd_reg.group_ident != 64'd0) && !cmd_reg.group_ident[63];
        kent   = krow_reg[khit_idx_reg];
        gent   = grow_reg[ghit_idx_reg];
        ksum_c = sat_add(khit_reg ? kent.cost : 48'd0, cmd_reg.cost_amount);
        ksum_t = sat_add(khit_reg ? kent.tokens : 48'd0, cmd_reg.token_amount);
        gsum_c = sat_add(ghit_reg ? gent.cost : 48'd0, cmd_reg.cost_amount);
        kway   = khit_reg ? khit_idx_reg : kfree_idx_reg;
        gway   = ghit_reg ? ghit_idx_reg : gfree_idx_reg;
        krow_upd = krow_reg;
        krow_upd[kway] = '{valid: 1'b1, ident: cmd_reg.key_ident,
                           cost: ksum_c, tokens: ksum_t};
        grow_upd = grow_reg;
        grow_upd[gway] = '{valid: 1'b1, ident: cmd_reg.group_ident, cost: gsum_c};
        k_wr = 1'b0;
        g_wr = 1'b0;
        res_exec = res_reg;
        unique case (cmd_reg.opcode)
            pqm_pkg::OP_CHECK: begin
                if (kpos && khit_reg) begin
                    if (cmd_reg.key_cost_limit != 48'd0
                        && kent.cost >= cmd_reg.key_cost_limit) begin
                        res_exec.verdict = pqm_pkg::VD_KEY_COST;
                    end else if (cmd_reg.key_token_limit != 48'd0
                        && kent.tokens >= cmd_reg.key_token_limit) begin
                        res_exec.verdict = pqm_pkg::VD_KEY_TOKEN;
                    end
                end
                if (res_exec.verdict == pqm_pkg::VD_ALLOW && gpos && ghit_reg
                    && cmd_reg.group_cost_limit != 48'd0
                    && gent.cost >= cmd_reg.group_cost_limit) begin
                    res_exec.verdict = pqm_pkg::VD_GRP_COST;
                end
            end
            pqm_pkg::OP_RECORD: begin
                k_wr = kpos && (khit_reg || kfree_reg);
                g_wr = gpos && (ghit_reg || gfree_reg);
                res_exec.record_dropped = (kpos && !khit_reg && !kfree_reg)
                                       || (gpos && !ghit_reg && !gfree_reg);
            end
            pqm_pkg::OP_QKEY: begin
                res_exec.query_ok = kpos;
                if (kpos && khit_reg) begin
                    res_exec.usage_cost   = kent.cost;
                    res_exec.usage_tokens = kent.tokens;
                end
            end
            pqm_pkg::OP_QGROUP: begin
                res_exec.query_ok = gpos;
                if (gpos && ghit_reg) begin
                    res_exec.usage_cost = gent.cost;
                end
            end
            default: begin
            end
        endcase
    end

    // memory write port select: clearing pass or record update
    always_comb begin
        kwe    = 1'b0;
        gwe    = 1'b0;
        kwaddr = kb_reg;
        gwaddr = gb_reg;
        kwdata = krow_upd;
        gwdata = grow_upd;
        if (state_reg == B_SWEEP) begin
            kwe    = 1'b1;
            gwe    = 1'b1;
            kwaddr = idx_reg;
            gwaddr = idx_reg;
            kwdata = '0;
            gwdata = '0;
        end else if (state_reg == B_EXEC) begin
            kwe = k_wr;
            gwe = g_wr;
        end
    end

    // table memories
    always_ff @(posedge aclk) begin
        if (kwe) begin
            kmem[kwaddr] <= kwdata;
        end
        if (gwe) begin
            gmem[gwaddr] <= gwdata;
        end
        if (state_reg == B_READ) begin
            krow_reg <= kmem[kb_reg];
            grow_reg <= gmem[gb_reg];
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_SWEEP;
            init_reg    <= 1'b1;
            idx_reg     <= '0;
            period_reg  <= 24'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == B_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_SWEEP: begin
                    idx_reg <= idx_reg + BIW'(1);
                    if (idx_reg == BIW'(BUCKETS - 1)) begin
                        idx_reg <= '0;
                        if (init_reg) begin
                            init_reg  <= 1'b0;
                            state_reg <= B_IDLE;
                        end else if (cmd_reg.opcode == pqm_pkg::OP_CLEAR) begin
                            state_reg <= B_RESP;
                        end else begin
                            state_reg <= B_READ;
                        end
                    end
                end
                B_IDLE: begin
                    if (q_valid) begin
                        if (roll) begin
                            period_reg <= q_req.period_stamp;
                            idx_reg    <= '0;
                            state_reg  <= B_SWEEP;
                        end else if (q_req.opcode <= pqm_pkg::OP_QGROUP) begin
                            state_reg <= B_READ;
                        end else begin
                            state_reg <= B_RESP;
                        end
                    end
                end
                B_READ: state_reg <= B_LOOK;
                B_LOOK: state_reg <= B_EXEC;
                B_EXEC: state_reg <= B_RESP;
                B_RESP: begin
                    if (out_free) begin
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    // request, match and result registers
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg <= q_req;
            kb_reg  <= q_kb;
            gb_reg  <= q_gb;
            res_reg <= '{record_dropped: 1'b0, usage_tokens: 48'd0, usage_cost: 48'd0,
                         query_ok: 1'b1, verdict: pqm_pkg::VD_ALLOW};
        end
        if (state_reg == B_LOOK) begin
            khit_reg      <= khit;
            kfree_reg     <= kfree;
            ghit_reg      <= ghit;
            gfree_reg     <= gfree;
            khit_idx_reg  <= khit_idx;
            kfree_idx_reg <= kfree_idx;
            ghit_idx_reg  <= ghit_idx;
            gfree_idx_reg <= gfree_idx;
        end
        if (state_reg == B_EXEC) begin
            res_reg <= res_exec;
        end
        if (state_reg == B_RESP && out_free) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(pqm_pkg::OUT_W - $bits(pqm_pkg::res_t))'(0), m_data_reg};

    // no request leaves the queue during the reset clearing pass
    a_no_pop_in_init: assert property (@(posedge aclk) disable iff (!aresetn)
        init_reg |-> !q_pop) else $error("queue popped during clearing pass");

    // table updates only come from a record or a clearing pass
    a_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (kwe || gwe) |-> (state_reg == B_SWEEP
                       || cmd_reg.opcode == pqm_pkg::OP_RECORD))
        else $error("table write outside record or clear");

    // a clearing pass always follows a clear, or a check or record whose period differs
    a_roll_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && roll) |=> (state_reg == B_SWEEP && idx_reg == '0))
        else $error("period change without clearing pass");

endmodule

// ----- hdl/per_id_quota_meter.sv -----
// per_id_quota_meter: top level of the per-key and per-group usage meter
// uses pqm_pkg, pqm_front, pqm_queue and pqm_back

// In the front part each request waits on the hash unit (two 64-bit multiplies
// as three 32x32 partial products each, then the bucket remainder at four
// bits a cycle); the back part reads, updates and writes a bucket row while
// the next request hashes. A clear, or a check or record that starts a new
// period, adds a clearing pass through both tables. After reset the same
// clearing pass runs with s_tready low. Results come out in request order
// through an output register, so the next request is taken while a result
// waits on m_tready.

module per_id_quota_meter #(
    parameter int BUCKETS = 1024,
    parameter int WAYS = 4
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // key_ident, group_ident, cost_amount, token_amount, key_cost_limit,
    // key_token_limit, group_cost_limit, period_stamp
    input  logic [pqm_pkg::IN_W-1:0]  s_tdata,
    // opcode
    input  logic [2:0]                s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // verdict, query_ok, usage_cost, usage_tokens, record_dropped, zero pad
    output logic [pqm_pkg::OUT_W-1:0] m_tdata
);

    localparam int BIW = $clog2(BUCKETS);
    localparam int RW  = $bits(pqm_pkg::req_t);
    localparam int QW  = RW + 2 * BIW;

    logic           q_full, q_push, q_pop, q_valid, init_busy;
    pqm_pkg::req_t  f_req;
    logic [BIW-1:0] f_kb, f_gb;
    logic [QW-1:0]  q_rdata;

    // front: accept and hash
    pqm_front #(.BUCKETS(BUCKETS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .hold     (init_busy),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_req    (f_req),
        .q_kb     (f_kb),
        .q_gb     (f_gb)
    );

    // request queue
    pqm_queue #(.W(QW)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   ({f_req, f_kb, f_gb}),
        .pop     (q_pop),
        .full    (q_full),
        .valid   (q_valid),
        .rdata   (q_rdata)
    );

    // back: table access and results
    pqm_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_req     (pqm_pkg::req_t'(q_rdata[QW-1:2*BIW])),
        .q_kb      (q_rdata[2*BIW-1:BIW]),
        .q_gb      (q_rdata[BIW-1:0]),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
